// ----- design/hra_pkg.sv -----
// Shared types and constants for the sample history ring with autoscale.
// No dependencies; the top level, controller and datapath import this package.
package hra_pkg;

   // Operation codes carried in the request mode field
   typedef enum logic [1:0] {
      MODE_PUSH  = 2'd0,
      MODE_READ  = 2'd1,
      MODE_SCALE = 2'd2,
      MODE_CLEAR = 2'd3
   } hra_mode_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] sample;
      logic [6:0]  age_index;
   } hra_req_type;

   typedef struct packed {
      logic [31:0] data;
      logic [7:0]  fill_count;
      logic        saturated;
   } hra_rsp_type;

   // Register map: index taken from address bit 2
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam logic        CSR_IDX_MIN  = 1'b0;
   localparam logic        CSR_IDX_PCT  = 1'b1;

   // Scale arithmetic constants
   // floor(z/5) = (z * DIV5_RECIP) >> 34 for any 32-bit z
   localparam logic [31:0] DIV5_RECIP   = 32'hCCCC_CCCD;
   localparam logic [6:0]  PCT_NUM      = 7'd95;
   localparam logic [6:0]  PCT_ROUND    = 7'd99;
   localparam int unsigned PCT_MIN_CNT  = 20;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_RANK_DIV,
      ST_OUTER_RD,
      ST_OUTER_WT,
      ST_INNER,
      ST_MAX_SCAN,
      ST_SCALE_DIV
   } hra_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic do_push;
      logic do_clear;
      logic rd_age;
      logic out_read;
      logic out_min;
      logic out_acc;
      logic out_scale;
      logic div_rank;
      logic take_rank;
      logic rd_outer;
      logic latch_v;
      logic next_i;
      logic scan_start;
      logic div_scale_v;
      logic div_scale_acc;
   } hra_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic count_zero;
      logic pct_sel;
      logic out_free;
      logic out_pending;
      logic div_done;
      logic scan_done;
      logic rank_hit;
      logic acc_above_min;
   } hra_status_type;

endpackage

// ----- design/history_ring_autoscale.sv -----
// Maximum scale: one RAM read per stored sample, then a reciprocal divide pass and
// an add; the divide and add are skipped when no sample lies above the minimum.
// Percentile scale: rank divide, candidate loop over the single RAM read port, then
// scale divide. One item at a time; sync active-high reset empties the ring and
// clears the configuration registers and the result valid flag.
module history_ring_autoscale import hra_pkg::*; #(
   parameter int unsigned DEPTH = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  hra_req_type           req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output hra_rsp_type           rsp_payload,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic           csr_wr;
   logic [31:0]    min_scale_ff;
   logic           pct_mode_ff;
   hra_cmd_type    cmd;
   hra_status_type status;

   // Configuration registers
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_scale_ff <= '0;
         pct_mode_ff  <= 1'b0;
      end else if (csr_wr) begin
         if (paddr[2] == CSR_IDX_MIN) begin
            min_scale_ff <= pwdata;
         end
         if (paddr[2] == CSR_IDX_PCT) begin
            pct_mode_ff <= pwdata[0];
         end
      end
   end

   assign prdata = (paddr[2] == CSR_IDX_MIN) ? min_scale_ff : {31'd0, pct_mode_ff};

   hra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_payload.mode),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   hra_dp #(.DEPTH(DEPTH)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_payload     (req_payload),
      .min_scale       (min_scale_ff),
      .percentile_mode (pct_mode_ff),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_payload     (rsp_payload)
   );

endmodule

// ----- design/hra_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hra_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/hra_ctrl.sv -----
// Sequencer for the history ring: accepts requests and steps the scale query.
// Depends on hra_pkg for state, command and status types.
module hra_ctrl import hra_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic [1:0]     req_mode,
   output logic           req_stall,
   input  hra_status_type status,
   output hra_cmd_type    cmd
);

   hra_state_type state_ff, state_in;
   logic          accept;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = !((state_ff == ST_IDLE) && status.out_free);
   assign accept    = req_valid && !req_stall;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (hra_mode_type'(req_mode))
                  MODE_PUSH:  cmd.do_push = 1'b1;
                  MODE_READ: begin
                     cmd.rd_age = 1'b1;
                     state_in   = ST_READ;
                  end
                  MODE_SCALE: begin
                     if (status.count_zero) begin
                        cmd.out_min = 1'b1;
                     end else if (status.pct_sel) begin
                        cmd.div_rank = 1'b1;
                        state_in     = ST_RANK_DIV;
                     end else begin
                        cmd.scan_start = 1'b1;
                        state_in       = ST_MAX_SCAN;
                     end
                  end
                  MODE_CLEAR: cmd.do_clear = 1'b1;
                  default:    cmd.do_clear = 1'b1;
               endcase
            end
         end
         ST_READ: begin
            cmd.out_read = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_RANK_DIV: begin
            if (status.div_done) begin
               cmd.take_rank = 1'b1;
               state_in      = ST_OUTER_RD;
            end
         end
         ST_OUTER_RD: begin
            cmd.rd_outer = 1'b1;
            state_in     = ST_OUTER_WT;
         end
         ST_OUTER_WT: begin
            cmd.latch_v    = 1'b1;
            cmd.scan_start = 1'b1;
            state_in       = ST_INNER;
         end
         ST_INNER: begin
            if (status.scan_done) begin
               if (status.rank_hit) begin
                  cmd.div_scale_v = 1'b1;
                  state_in        = ST_SCALE_DIV;
               end else begin
                  cmd.next_i = 1'b1;
                  state_in   = ST_OUTER_RD;
               end
            end
         end
         ST_MAX_SCAN: begin
            if (status.scan_done) begin
               if (status.acc_above_min) begin
                  cmd.div_scale_acc = 1'b1;
                  state_in          = ST_SCALE_DIV;
               end else begin
                  cmd.out_acc = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         ST_SCALE_DIV: begin
            if (status.div_done) begin
               cmd.out_scale = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output register stays empty while an operation is in flight
   a_busy_out_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !status.out_pending)
      else $error("result pending while operation in flight");

   // A read always completes in the following cycle
   a_read_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_IDLE))
      else $error("read did not complete");

endmodule

// ----- design/hra_dp.sv -----
// Datapath: ring pointers, sample RAM, scan engine, reciprocal divider, result register.
// Depends on hra_pkg and hra_ram.
module hra_dp import hra_pkg::*; #(
   parameter int unsigned DEPTH = 128
) (
   input  logic           clock,
   input  logic           reset,
   input  hra_req_type    req_payload,
   input  logic [31:0]    min_scale,
   input  logic           percentile_mode,
   input  hra_cmd_type    cmd,
   output hra_status_type status,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output hra_rsp_type    rsp_payload
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned AGE_W = 7;
   localparam int unsigned IDX_W = (CNT_W > AGE_W) ? CNT_W : AGE_W;
   localparam int unsigned RNK_W = CNT_W + 8;

   logic [PTR_W-1:0] oldest_ff, oldest_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] i_ff;
   logic [CNT_W-1:0] rank_ff;
   logic [31:0]      v_ff;
   logic             rd_hit_ff;

   logic [CNT_W-1:0] scan_idx_ff;
   logic             scan_busy_ff, scan_pend_ff, scan_issue;
   logic [31:0]      acc_ff;
   logic [CNT_W-1:0] below_ff, not_above_ff;

   logic [31:0]      div_z_ff, div_base_ff;
   logic [32:0]      div_quo_ff;
   logic [1:0]       div_cnt_ff, div_passes_ff;
   logic             div_busy_ff, div_done_ff;
   logic             div_start;
   logic [31:0]      div_z_in, div_base_in;
   logic [1:0]       div_passes_in;
   logic [33:0]      triple_v;
   logic [63:0]      div_prod;

   logic             rsp_valid_ff;
   hra_rsp_type      rsp_payload_ff;

   logic             wr_en;
   logic [PTR_W-1:0] wr_addr, rd_addr;
   logic [31:0]      rd_data;
   logic [IDX_W-1:0] age_ext, count_ext;
   logic [RNK_W-1:0] rank_div;
   logic             q_sat;
   logic [31:0]      q_val;
   logic             out_load;
   logic [31:0]      out_data;
   logic             out_sat;

   // Ring slot of an offset from the oldest sample
   function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] ofs);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(ofs);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return PTR_W'(sum);
   endfunction

   assign age_ext   = IDX_W'(req_payload.age_index);
   assign count_ext = IDX_W'(count_ff);

   // Sample store
   assign wr_en   = cmd.do_push;
   assign wr_addr = (count_ff < CNT_W'(DEPTH)) ? slot_of(oldest_ff, count_ff) : oldest_ff;

   always_comb begin
      if (cmd.rd_age) begin
         rd_addr = slot_of(oldest_ff, CNT_W'(age_ext));
      end else if (cmd.rd_outer) begin
         rd_addr = slot_of(oldest_ff, i_ff);
      end else begin
         rd_addr = slot_of(oldest_ff, scan_idx_ff);
      end
   end

   hra_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_payload.sample),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Ring pointers
   always_comb begin
      count_in  = count_ff;
      oldest_in = oldest_ff;
      if (cmd.do_push) begin
         if (count_ff < CNT_W'(DEPTH)) begin
            count_in = count_ff + CNT_W'(1);
         end else if (oldest_ff == PTR_W'(DEPTH - 1)) begin
            oldest_in = '0;
         end else begin
            oldest_in = oldest_ff + PTR_W'(1);
         end
      end else if (cmd.do_clear) begin
         count_in  = '0;
         oldest_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         oldest_ff <= '0;
      end else begin
         count_ff  <= count_in;
         oldest_ff <= oldest_in;
      end
   end

   // Read hit flag, outer index, rank and candidate value
   always_ff @(posedge clock) begin
      if (cmd.rd_age) begin
         rd_hit_ff <= (age_ext < count_ext);
      end
      if (cmd.take_rank) begin
         rank_ff <= CNT_W'(div_quo_ff - 33'd1);
         i_ff    <= '0;
      end else if (cmd.next_i) begin
         i_ff <= i_ff + CNT_W'(1);
      end
      if (cmd.latch_v) begin
         v_ff <= rd_data;
      end
   end

   // Scan engine: one address a step, data from the RAM in the next cycle
   assign scan_issue = scan_busy_ff && (scan_idx_ff < count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_busy_ff <= 1'b0;
         scan_pend_ff <= 1'b0;
      end else if (cmd.scan_start) begin
         scan_busy_ff <= 1'b1;
         scan_pend_ff <= 1'b0;
      end else begin
         scan_pend_ff <= scan_issue;
         if (scan_busy_ff && !scan_issue && !scan_pend_ff) begin
            scan_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         scan_idx_ff  <= '0;
         acc_ff       <= min_scale;
         below_ff     <= '0;
         not_above_ff <= '0;
      end else begin
         if (scan_issue) begin
            scan_idx_ff <= scan_idx_ff + CNT_W'(1);
         end
         if (scan_pend_ff) begin
            if (rd_data > acc_ff) begin
               acc_ff <= rd_data;
            end
            if (rd_data < v_ff) begin
               below_ff <= below_ff + CNT_W'(1);
            end
            if (rd_data <= v_ff) begin
               not_above_ff <= not_above_ff + CNT_W'(1);
            end
         end
      end
   end

   // Divider operands: rank is floor((95n+99)/4)/5/5; v*115/100 is v + floor(3v/4)/5;
   // m*105/100 is m + floor(m/4)/5
   assign rank_div  = RNK_W'(count_ff) * RNK_W'(PCT_NUM) + RNK_W'(PCT_ROUND);
   assign div_start = cmd.div_rank || cmd.div_scale_v || cmd.div_scale_acc;
   assign triple_v  = {1'b0, v_ff, 1'b0} + {2'b00, v_ff};

   always_comb begin
      if (cmd.div_rank) begin
         div_z_in      = 32'(rank_div >> 2);
         div_base_in   = '0;
         div_passes_in = 2'd2;
      end else if (cmd.div_scale_v) begin
         div_z_in      = triple_v[33:2];
         div_base_in   = v_ff;
         div_passes_in = 2'd1;
      end else begin
         div_z_in      = {2'b00, acc_ff[31:2]};
         div_base_in   = acc_ff;
         div_passes_in = 2'd1;
      end
   end

   // Divide by 5 through the reciprocal, one pass a cycle, then add the base
   assign div_prod = {32'd0, div_z_ff} * {32'd0, DIV5_RECIP};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_done_ff <= 1'b0;
      end else if (div_start) begin
         div_busy_ff <= 1'b1;
         div_done_ff <= 1'b0;
      end else if (div_busy_ff && (div_cnt_ff == div_passes_ff)) begin
         div_busy_ff <= 1'b0;
         div_done_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (div_start) begin
         div_z_ff      <= div_z_in;
         div_base_ff   <= div_base_in;
         div_passes_ff <= div_passes_in;
         div_cnt_ff    <= '0;
      end else if (div_busy_ff) begin
         if (div_cnt_ff == div_passes_ff) begin
            div_quo_ff <= {1'b0, div_base_ff} + {1'b0, div_z_ff};
         end else begin
            div_z_ff   <= {2'b00, div_prod[63:34]};
            div_cnt_ff <= div_cnt_ff + 2'd1;
         end
      end
   end

   // Saturate the scaled quotient
   assign q_sat = div_quo_ff[32];
   assign q_val = q_sat ? 32'hFFFF_FFFF : div_quo_ff[31:0];

   // Result selection
   assign out_load = cmd.do_push || cmd.do_clear || cmd.out_read || cmd.out_min ||
                     cmd.out_acc || cmd.out_scale;

   always_comb begin
      out_data = '0;
      out_sat  = 1'b0;
      if (cmd.out_read) begin
         out_data = rd_hit_ff ? rd_data : '0;
      end else if (cmd.out_min) begin
         out_data = min_scale;
      end else if (cmd.out_acc) begin
         out_data = acc_ff;
      end else if (cmd.out_scale) begin
         out_data = (q_val < min_scale) ? min_scale : q_val;
         out_sat  = q_sat;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_payload_ff.data       <= out_data;
         rsp_payload_ff.fill_count <= 8'(count_in);
         rsp_payload_ff.saturated  <= out_sat;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Status to the controller
   assign status.count_zero    = (count_ff == '0);
   assign status.pct_sel       = percentile_mode && (32'(count_ff) >= PCT_MIN_CNT);
   assign status.out_free      = !rsp_valid_ff || !rsp_stall;
   assign status.out_pending   = rsp_valid_ff;
   assign status.div_done      = div_done_ff;
   assign status.scan_done     = scan_busy_ff && !scan_issue && !scan_pend_ff;
   assign status.rank_hit      = (below_ff <= rank_ff) && (rank_ff < not_above_ff);
   assign status.acc_above_min = (acc_ff > min_scale);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond ring depth");

   a_wrap_only_full: assert property (@(posedge clock) disable iff (reset)
      (oldest_ff != '0) |-> (count_ff == CNT_W'(DEPTH)))
      else $error("oldest pointer moved on a ring that is not full");

   a_div_scan_excl: assert property (@(posedge clock) disable iff (reset)
      !(div_busy_ff && scan_busy_ff))
      else $error("divider and scan active together");

endmodule
